FILE: rtl/tspcc_pkg.sv
// ----------------------------------------------------------------------------
// tspcc_pkg
// Shared types and constants for the transport stream continuity checker.
// ----------------------------------------------------------------------------
package tspcc_pkg;

   // field widths fixed by the packet header layout
   localparam int PID_W   = 13;
   localparam int BYTE_W  = 8;
   localparam int CC_W    = 4;
   localparam int SCR_W   = 2;
   localparam int EVENT_W = 2;

   localparam logic [PID_W-1:0]  NULL_PID   = 13'h1FFF;
   localparam logic [BYTE_W-1:0] MAX_AF_LEN = 8'd183;
   // pcr needs six bytes after the flags byte
   localparam logic [BYTE_W-1:0] MIN_PCR_AF_LEN = 8'd7;

   // bit positions in the adaptation flags byte
   localparam int FLAG_DISC_BIT = 7;
   localparam int FLAG_PCR_BIT  = 4;

   // continuity event codes
   typedef enum logic [EVENT_W-1:0] {
      EV_NONE   = 2'd0,
      EV_DUP    = 2'd1,
      EV_CC_ERR = 2'd2,
      EV_DISC   = 2'd3
   } event_type;

   // per-pid table entry, init flag in bit 0
   typedef struct packed {
      logic [CC_W-1:0] expct;
      logic            dup;
      logic            init;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // classification of one packet plus the table write it causes
   typedef struct packed {
      event_type ev;
      logic      malformed;
      logic      null_pkt;
      logic      payload;
      logic      wr_en;
      entry_type next;
   } class_type;

endpackage

FILE: rtl/ts_pid_continuity_checker.sv
// ----------------------------------------------------------------------------
// ts_pid_continuity_checker
// Per-PID continuity counter check for MPEG transport stream packet headers.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries header bytes 1..3 plus the adaptation length and flags
//   bytes of one packet; rsp_* returns the decoded PID, scrambling bits,
//   continuity event, null, malformed and payload flags. Both channels
//   transfer on a rising edge with valid high and stall low.
//   rsp_valid rises after the table read stage and the output register.
//   Throughput: one packet per cycle while neither a stall nor the
//   clearing pass holds the flow. The per-PID table sits in one RAM
//   with a registered read; the entry written by the previous packet is
//   forwarded so that back-to-back packets on one PID see it.
//   Reset: the table is swept to zero, one entry a cycle, over addresses
//   0 to PID_COUNT-1; req_stall stays high during that pass.
//   Receiver stall: the result holds in the output register; one more
//   packet can wait in the read stage, then req_stall rises.
// ----------------------------------------------------------------------------
module ts_pid_continuity_checker
   import tspcc_pkg::*;
#(
   parameter int PID_COUNT = 8192
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [BYTE_W-1:0]  req_header_byte_1,
   input  logic [BYTE_W-1:0]  req_header_byte_2,
   input  logic [BYTE_W-1:0]  req_header_byte_3,
   input  logic [BYTE_W-1:0]  req_af_length,
   input  logic [BYTE_W-1:0]  req_af_flags,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [PID_W-1:0]   rsp_pid,
   output logic [SCR_W-1:0]   rsp_scrambling,
   output logic [EVENT_W-1:0] rsp_event_res,
   output logic               rsp_null_packet,
   output logic               rsp_malformed,
   output logic               rsp_carries_payload
);

   localparam int AW = $clog2(PID_COUNT);

   // clearing pass
   logic          clear_ff, clear_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // read stage
   logic              s1_valid_ff, s1_valid_in;
   logic [PID_W-1:0]  s1_pid_ff;
   logic [BYTE_W-1:0] s1_hdr3_ff;
   logic [BYTE_W-1:0] s1_len_ff;
   logic [BYTE_W-1:0] s1_flags_ff;

   // last item write for forwarding
   logic          fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0] fwd_addr_ff;
   entry_type     fwd_data_ff;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PID_W-1:0]   rsp_pid_ff;
   logic [SCR_W-1:0]   rsp_scr_ff;
   logic [EVENT_W-1:0] rsp_event_ff;
   logic               rsp_null_ff;
   logic               rsp_malformed_ff;
   logic               rsp_payload_ff;

   logic             req_take;
   logic             s1_fire;
   logic [PID_W-1:0] req_pid;
   logic [AW-1:0]    s1_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type        prev;
   class_type        cls;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   // handshake
   assign req_pid   = {req_header_byte_1[4:0], req_header_byte_2};
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clear_ff || (s1_valid_ff && !s1_fire);
   assign req_take  = req_valid && !req_stall;
   assign s1_addr   = s1_pid_ff[AW-1:0];

   // table memory
   tspcc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PID_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req_take),
      .rd_addr (req_pid[AW-1:0]),
      .rd_data (rd_data)
   );

   // entry read with forwarding of the newest write
   assign prev = (fwd_valid_ff && (fwd_addr_ff == s1_addr)) ? fwd_data_ff
                                                            : entry_type'(rd_data);

   tspcc_classify u_classify (
      .pid           (s1_pid_ff),
      .header_byte_3 (s1_hdr3_ff),
      .af_length     (s1_len_ff),
      .af_flags      (s1_flags_ff),
      .prev          (prev),
      .cls           (cls)
   );

   // write port: clearing pass or item write-back
   always_comb begin
      if (clear_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = s1_fire && cls.wr_en;
         wr_addr = s1_addr;
         wr_data = cls.next;
      end
   end

   // control next values
   always_comb begin
      clear_in     = clear_ff && (clr_addr_ff != AW'(PID_COUNT - 1));
      clr_addr_in  = clear_ff ? clr_addr_ff + AW'(1) : clr_addr_ff;
      s1_valid_in  = req_take || (s1_valid_ff && !s1_fire);
      fwd_valid_in = fwd_valid_ff || (s1_fire && cls.wr_en);
      rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // read stage payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pid_ff   <= req_pid;
         s1_hdr3_ff  <= req_header_byte_3;
         s1_len_ff   <= req_af_length;
         s1_flags_ff <= req_af_flags;
      end
   end

   // forwarding register
   always_ff @(posedge clock) begin
      if (s1_fire && cls.wr_en) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= cls.next;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_pid_ff       <= s1_pid_ff;
         rsp_scr_ff       <= s1_hdr3_ff[7:6];
         rsp_event_ff     <= cls.ev;
         rsp_null_ff      <= cls.null_pkt;
         rsp_malformed_ff <= cls.malformed;
         rsp_payload_ff   <= cls.payload;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pid             = rsp_pid_ff;
   assign rsp_scrambling      = rsp_scr_ff;
   assign rsp_event_res       = rsp_event_ff;
   assign rsp_null_packet     = rsp_null_ff;
   assign rsp_malformed       = rsp_malformed_ff;
   assign rsp_carries_payload = rsp_payload_ff;

endmodule

FILE: rtl/tspcc_ram.sv
// ----------------------------------------------------------------------------
// tspcc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tspcc_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tspcc_classify.sv
// ----------------------------------------------------------------------------
// tspcc_classify
// Decodes one packet header against its table entry and gives the event,
// the status flags and the updated entry.
// ----------------------------------------------------------------------------
module tspcc_classify
   import tspcc_pkg::*;
(
   input  logic [PID_W-1:0]  pid,
   input  logic [BYTE_W-1:0] header_byte_3,
   input  logic [BYTE_W-1:0] af_length,
   input  logic [BYTE_W-1:0] af_flags,
   input  entry_type         prev,
   output class_type         cls
);

   logic [1:0]      afc;
   logic [CC_W-1:0] cc;
   logic            has_af;
   logic            with_payload;
   logic            is_null;
   logic            disc;
   logic            bad_len;
   entry_type       fresh;

   // header decode
   assign afc          = header_byte_3[5:4];
   assign cc           = header_byte_3[CC_W-1:0];
   assign has_af       = afc[1];
   assign with_payload = afc[0];
   assign is_null      = (pid == NULL_PID);

   // entry after an in-order or resync packet
   always_comb begin
      fresh       = '0;
      fresh.expct = cc + CC_W'(1);
      fresh.dup   = 1'b1;
      fresh.init  = 1'b1;
   end

   // adaptation field checks
   always_comb begin
      disc    = 1'b0;
      bad_len = 1'b0;
      if (!is_null && has_af) begin
         if (af_length > MAX_AF_LEN) begin
            bad_len = 1'b1;
         end else if (af_length != '0) begin
            disc = af_flags[FLAG_DISC_BIT];
            if (af_flags[FLAG_PCR_BIT] && (af_length < MIN_PCR_AF_LEN)) begin
               bad_len = 1'b1;
            end
         end
      end
   end

   // continuity classification and entry update
   always_comb begin
      cls           = '0;
      cls.ev        = EV_NONE;
      cls.malformed = bad_len;
      cls.null_pkt  = is_null;
      cls.payload   = with_payload;
      cls.wr_en     = !is_null;
      cls.next      = prev;
      if (is_null) begin
         // null pid is never tracked
         cls.next = prev;
      end else if (disc) begin
         cls.next = '0;
         cls.ev   = EV_DISC;
      end else if (!with_payload) begin
         // adaptation-only or reserved control keeps the entry
         cls.next = prev;
      end else if (!prev.init) begin
         cls.next = fresh;
      end else if (cc == prev.expct) begin
         cls.next = fresh;
      end else if ((cc == (prev.expct - CC_W'(1))) && prev.dup) begin
         cls.next     = prev;
         cls.next.dup = 1'b0;
         cls.ev       = EV_DUP;
      end else begin
         cls.next = fresh;
         cls.ev   = EV_CC_ERR;
      end
   end

endmodule
